// ===== sv/lcf_pkg.sv =====
// ---------------------------------------------------------------------------
// Lattice cell fold package
// Shared constants, payload types and pipeline side-band type for the
// lattice cell fold block.
// ---------------------------------------------------------------------------
package lcf_pkg;

  // Fraction bits of the coordinate format.
  localparam int COORD_FRAC_BITS = 16;

  // Pitch after reset is 1.0 in the coordinate format.
  localparam logic [30:0] PITCH_RESET = 31'(64'd1 << COORD_FRAC_BITS);

  // sqrt(3) as unsigned Q1.30, rounded.
  localparam logic [30:0] SQRT3_Q30 = 31'd1859775393;

  // One remainder bit per divider stage.
  localparam int DIV_STAGES = 32;

  // Pattern codes.
  localparam logic [1:0] MODE_SQUARE  = 2'd0;
  localparam logic [1:0] MODE_CENTRED = 2'd1;
  localparam logic [1:0] MODE_HEX     = 2'd2;

  // Register indexes, decoded from address bit 2.
  localparam logic REG_CELL_PITCH   = 1'b0;
  localparam logic REG_PATTERN_MODE = 1'b1;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
  } local_t;

  // Per-item values derived from the configuration.
  typedef struct packed {
    logic [1:0]  mode;
    logic [30:0] pitch;
    logic [30:0] half_w;
    logic [30:0] row_h;
  } side_t;

endpackage

// ===== sv/lcf_fmod.sv =====
// ---------------------------------------------------------------------------
// Lattice cell fold floored modulo
// Pipelined restoring remainder, one bit per stage, with a floored sign fix
// on the last stage's output.
// ---------------------------------------------------------------------------
module lcf_fmod (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num_in,
  input  logic        neg_in,
  input  logic [31:0] div_in,
  output logic [31:0] rem_out
);

  localparam int N = lcf_pkg::DIV_STAGES;

  logic [31:0] rem_q [1:N];
  logic [31:0] num_q [1:N];
  logic [31:0] div_q [1:N];
  logic        neg_q [1:N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [31:0] r_src;
    logic [31:0] n_src;
    logic [31:0] d_src;
    logic        s_src;
    logic [32:0] trial;
    logic [32:0] diff;

    if (k == 0) begin : g_first
      assign r_src = '0;
      assign n_src = num_in;
      assign d_src = div_in;
      assign s_src = neg_in;
    end else begin : g_next
      assign r_src = rem_q[k];
      assign n_src = num_q[k];
      assign d_src = div_q[k];
      assign s_src = neg_q[k];
    end

    // Shift in the next dividend bit and subtract when it fits.
    assign trial = {r_src, n_src[31]};
    assign diff  = trial - {1'b0, d_src};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= diff[32] ? trial[31:0] : diff[31:0];
        num_q[k+1] <= {n_src[30:0], 1'b0};
        div_q[k+1] <= d_src;
        neg_q[k+1] <= s_src;
      end
    end
  end

  // A negative dividend with a nonzero remainder folds back into [0, m).
  assign rem_out = (neg_q[N] && (rem_q[N] != '0)) ? (div_q[N] - rem_q[N]) : rem_q[N];

endmodule

// ===== sv/lattice_cell_fold_core.sv =====
// ---------------------------------------------------------------------------
// Lattice cell fold core
// Folds a signed Q16.16 point into centred local coordinates of its square,
// centred square or hexagonal lattice cell.
// ---------------------------------------------------------------------------
// Usage:
// Points enter on in_valid/in_ready/in_data, one transaction per point, and
// results leave on out_valid/out_ready/out_data in the same order, one per
// point. The pitch and the pattern are to be set over the APB port only while
// no point is in flight; the block itself does not enforce this.
// The depth is set by the floored modulo: three 32-stage remainder pipelines
// (y, x and the shifted x of odd hexagonal rows) each resolve one bit per
// cycle while the pipeline is not held, with three stages before them for the
// pitch products and the dividends and three after for the odd-row fold and
// the hexagonal corner test, followed by the output register.
// Throughput is one point per cycle while the pipeline is not held.
// When the receiver stalls, one result waits in the output register and the
// next lands in a skid register; only then does in_ready fall and the whole
// pipeline hold. Nothing is lost or repeated.
// Reset clears all valid bits, sets the pitch to 1.0 and the pattern to square.
// ---------------------------------------------------------------------------
module lattice_cell_fold_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcf_pkg::point_t     in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output lcf_pkg::local_t     out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int N = lcf_pkg::DIV_STAGES;

  // Saturating subtract of a nonnegative offset.
  function automatic logic [31:0] sat_sub(logic [31:0] a, logic [30:0] b);
    logic [32:0] d;
    d = {a[31], a} - {2'b00, b};
    if (d[32] != d[31]) begin
      return 32'h8000_0000;
    end
    return d[31:0];
  endfunction

  // Configuration registers.
  logic [30:0] cell_pitch;
  logic [1:0]  pattern_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_pitch   <= lcf_pkg::PITCH_RESET;
      pattern_mode <= lcf_pkg::MODE_SQUARE;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        lcf_pkg::REG_CELL_PITCH:   cell_pitch   <= pwdata[30:0];
        lcf_pkg::REG_PATTERN_MODE: pattern_mode <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      lcf_pkg::REG_CELL_PITCH:   prdata = {1'b0, cell_pitch};
      lcf_pkg::REG_PATTERN_MODE: prdata = {30'b0, pattern_mode};
      default:                   prdata = '0;
    endcase
  end

  // The pipeline moves as long as the skid register is free.
  logic skid_valid;
  logic en;
  assign en       = !skid_valid;
  assign in_ready = en;

  // Stage 1: capture the point and form the pitch times sqrt(3) product.
  logic            v1;
  lcf_pkg::point_t pt1;
  logic [1:0]      mode1;
  logic [30:0]     p1;
  logic [61:0]     prod1;
  logic [30:0]     pitch_eff;

  assign pitch_eff = (cell_pitch == '0) ? 31'd1 : cell_pitch;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt1   <= in_data;
      mode1 <= pattern_mode;
      p1    <= pitch_eff;
      prod1 <= {31'b0, pitch_eff} * {31'b0, lcf_pkg::SQRT3_Q30};
    end
  end

  // Stage 2: half cell width and row height.
  logic            v2;
  lcf_pkg::point_t pt2;
  logic [1:0]      mode2;
  logic [30:0]     p2;
  logic [30:0]     a2;
  logic [30:0]     r2;
  logic [61:0]     a_sum;
  logic [32:0]     r_sum;
  logic [30:0]     a_c;

  assign a_sum = prod1 + 62'h8000_0000;
  assign a_c   = (a_sum[61:32] == '0) ? 31'd1 : {1'b0, a_sum[61:32]};
  assign r_sum = {2'b00, p1} + {1'b0, p1, 1'b0} + 33'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt2   <= pt1;
      mode2 <= mode1;
      p2    <= p1;
      a2    <= a_c;
      r2    <= r_sum[32:2];
    end
  end

  // Stage 3: choose dividends and divisors for the pattern.
  logic [30:0] half2;
  logic [31:0] x0_c;
  logic [31:0] x1_c;
  logic [31:0] y_c;
  logic [31:0] dx_c;
  logic [31:0] dy_c;

  assign half2 = p2 >> 1;

  always_comb begin
    case (mode2)
      lcf_pkg::MODE_HEX: begin
        y_c  = pt2.point_y;
        x0_c = pt2.point_x;
        x1_c = sat_sub(pt2.point_x, a2);
        dy_c = {r2, 1'b0};
        dx_c = {a2, 1'b0};
      end
      lcf_pkg::MODE_CENTRED: begin
        y_c  = sat_sub(pt2.point_y, half2);
        x0_c = sat_sub(pt2.point_x, half2);
        x1_c = x0_c;
        dy_c = {1'b0, p2};
        dx_c = {1'b0, p2};
      end
      default: begin
        y_c  = pt2.point_y;
        x0_c = pt2.point_x;
        x1_c = x0_c;
        dy_c = {1'b0, p2};
        dx_c = {1'b0, p2};
      end
    endcase
  end

  logic           vd;
  lcf_pkg::side_t side_d;
  logic [31:0]    x0_mag, x1_mag, y_mag;
  logic           x0_neg, x1_neg, y_neg;
  logic [31:0]    dx_d, dy_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d.mode   <= mode2;
      side_d.pitch  <= p2;
      side_d.half_w <= a2;
      side_d.row_h  <= r2;
      x0_neg <= x0_c[31];
      x1_neg <= x1_c[31];
      y_neg  <= y_c[31];
      x0_mag <= x0_c[31] ? (32'd0 - x0_c) : x0_c;
      x1_mag <= x1_c[31] ? (32'd0 - x1_c) : x1_c;
      y_mag  <= y_c[31] ? (32'd0 - y_c) : y_c;
      dx_d   <= dx_c;
      dy_d   <= dy_c;
    end
  end

  // Remainder pipelines.
  logic [31:0] rx0_c, rx1_c, ry_c;

  lcf_fmod u_mod_x0 (.clk(clk), .en(en), .num_in(x0_mag), .neg_in(x0_neg), .div_in(dx_d),
                     .rem_out(rx0_c));
  lcf_fmod u_mod_x1 (.clk(clk), .en(en), .num_in(x1_mag), .neg_in(x1_neg), .div_in(dx_d),
                     .rem_out(rx1_c));
  lcf_fmod u_mod_y  (.clk(clk), .en(en), .num_in(y_mag), .neg_in(y_neg), .div_in(dy_d),
                     .rem_out(ry_c));

  // Valid bits and side-band travel beside the remainder stages.
  logic           vq    [1:N];
  lcf_pkg::side_t side_q[1:N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 1; k <= N; k++) begin
        vq[k] <= 1'b0;
      end
    end else if (en) begin
      vq[1] <= vd;
      for (int k = 1; k < N; k++) begin
        vq[k+1] <= vq[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[1] <= side_d;
      for (int k = 1; k < N; k++) begin
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // Fold stage 1: register the floored remainders.
  logic           vf1;
  lcf_pkg::side_t side_f1;
  logic [31:0]    rx0_f1, rx1_f1, ry_f1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vf1 <= 1'b0;
    end else if (en) begin
      vf1 <= vq[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_f1 <= side_q[N];
      rx0_f1  <= rx0_c;
      rx1_f1  <= rx1_c;
      ry_f1   <= ry_c;
    end
  end

  // Fold stage 2: odd hexagonal rows take the shifted x.
  logic           vf2;
  lcf_pkg::side_t side_f2;
  logic [31:0]    xh_f2, yh_f2, rx0_f2, ry_f2;
  logic           far_row;

  assign far_row = ry_f1 > {1'b0, side_f1.row_h};

  always_ff @(posedge clk) begin
    if (rst) begin
      vf2 <= 1'b0;
    end else if (en) begin
      vf2 <= vf1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_f2 <= side_f1;
      xh_f2   <= far_row ? rx1_f1 : rx0_f1;
      yh_f2   <= far_row ? (ry_f1 - {1'b0, side_f1.row_h}) : ry_f1;
      rx0_f2  <= rx0_f1;
      ry_f2   <= ry_f1;
    end
  end

  // Fold stage 3: corner test products.
  logic           vf3;
  lcf_pkg::side_t side_f3;
  logic [31:0]    xh_f3, yh_f3, rx0_f3, ry_f3;
  logic [65:0]    lhs_f3;
  logic [63:0]    rhs_f3;
  logic [31:0]    dry;
  logic [32:0]    dax;
  logic [31:0]    adx;

  assign dry = {1'b0, side_f2.row_h} - yh_f2;
  assign dax = {2'b00, side_f2.half_w} - {1'b0, xh_f2};
  assign adx = dax[32] ? 32'(33'd0 - dax) : dax[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vf3 <= 1'b0;
    end else if (en) begin
      vf3 <= vf2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_f3 <= side_f2;
      xh_f3   <= xh_f2;
      yh_f3   <= yh_f2;
      rx0_f3  <= rx0_f2;
      ry_f3   <= ry_f2;
      lhs_f3  <= {64'(dry) * 64'(side_f2.half_w), 2'b00};
      rhs_f3  <= 64'(adx) * 64'(side_f2.pitch);
    end
  end

  // Final offsets to the cell centre.
  logic [30:0]       half_f;
  logic [30:0]       quart_f;
  logic              flip;
  logic signed [33:0] xs, ys, lx, ly;
  lcf_pkg::local_t   res_c;

  assign half_f  = side_f3.pitch >> 1;
  assign quart_f = side_f3.pitch >> 2;
  assign flip    = (yh_f3 > {1'b0, half_f}) && (lhs_f3 < {2'b00, rhs_f3});

  always_comb begin
    if (side_f3.mode == lcf_pkg::MODE_HEX) begin
      if (flip) begin
        ys = {2'b00, yh_f3} - {3'b000, side_f3.row_h};
        xs = (xh_f3 > {1'b0, side_f3.half_w}) ?
             ({2'b00, xh_f3} - {3'b000, side_f3.half_w}) :
             ({2'b00, xh_f3} + {3'b000, side_f3.half_w});
      end else begin
        ys = {2'b00, yh_f3};
        xs = {2'b00, xh_f3};
      end
      lx = xs - {3'b000, side_f3.half_w};
      ly = ys - {3'b000, quart_f};
    end else begin
      xs = {2'b00, rx0_f3};
      ys = {2'b00, ry_f3};
      lx = xs - {3'b000, half_f};
      ly = ys - {3'b000, half_f};
    end
    res_c.local_x = lx[31:0];
    res_c.local_y = ly[31:0];
  end

  // Output register with a skid register behind it.
  lcf_pkg::local_t skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= vf3;
      end
    end else if (en && vf3) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : res_c;
    end
    if (out_valid && !out_ready && en && vf3) begin
      skid_data <= res_c;
    end
  end

  // The skid register only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result with the output register empty");

  // A finished result arriving at a stalled output is parked, not dropped.
  a_park_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && en && vf3) |=> skid_valid)
    else $error("result lost at stalled output");

  // An accepted transaction enters the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> v1)
    else $error("accepted transaction missing from first stage");

endmodule
